FILE: hw/rtl/iss_pkg.sv
// Shared types and constants for the indexed sequence store.
// No dependencies; imported by every module of the block.
package iss_pkg;

  localparam int DEPTH       = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = 7;
  localparam int POS_W       = 7;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam logic [OP_W-1:0] OP_READ      = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd4;

  localparam logic [DATA_W-1:0] EMPTY_READ = 32'hFFFF_FC19;  // -999

  // request broadcast to every cell
  typedef struct packed {
    logic              apply;   // commit insert/remove/overwrite this cycle
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [CNT_W-1:0]  cnt;
    logic [POS_W-1:0]  target;  // clamped read position
  } cmd_t;

  // result token passed from cell to cell
  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } car_t;

endpackage

FILE: hw/rtl/iss_cell.sv
// One storage cell of the sequence chain: holds one entry, shifts with its
// neighbors on insert/remove, and forwards the lookup token. Uses iss_pkg.
module iss_cell (
  input  logic                      clk,
  input  logic [iss_pkg::IDX_W-1:0] idx,
  input  iss_pkg::cmd_t             cmd,
  input  logic [iss_pkg::DATA_W-1:0] left_data,
  input  logic [iss_pkg::DATA_W-1:0] right_data,
  output logic [iss_pkg::DATA_W-1:0] data_o,
  input  iss_pkg::car_t             car_i,
  output iss_pkg::car_t             car_o
);
  import iss_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  car_t              car_r, car_nxt;
  logic [POS_W-1:0]  my_pos;
  logic              hit;

  assign my_pos = POS_W'(idx);

  always_comb begin
    data_nxt = data_r;
    if (cmd.apply) begin
      case (cmd.op)
        OP_INSERT: begin
          if (my_pos > cmd.pos) data_nxt = left_data;
          else if (my_pos == cmd.pos) data_nxt = cmd.val;
        end
        OP_REMOVE: begin
          if (my_pos >= cmd.pos) data_nxt = right_data;
        end
        OP_OVERWRITE: begin
          if (my_pos == cmd.pos) data_nxt = cmd.val;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_comb begin
    if (cmd.op == OP_READ) hit = (my_pos == cmd.target);
    else hit = (my_pos < cmd.cnt) && (data_r == cmd.val);
    car_nxt = car_i;
    if (!car_i.found && hit) begin
      car_nxt.found = 1'b1;
      car_nxt.pos   = my_pos;
      car_nxt.data  = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    car_r  <= car_nxt;
  end

  assign data_o = data_r;
  assign car_o  = car_r;

endmodule

FILE: hw/rtl/iss_ctrl.sv
// Request sequencer: input/output handshakes, entry count, scan timing and
// result formatting for the cell chain. Uses iss_pkg.
module iss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [iss_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [iss_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [iss_pkg::OUT_TDATA_W-1:0] out_tdata,
  output iss_pkg::cmd_t                  cmd,
  input  iss_pkg::car_t                  car_end
);
  import iss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W:0]    scan_r, scan_nxt;
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;

  logic              res_ok_r, res_ok_nxt;
  logic [DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic [POS_W-1:0]  res_fp_r, res_fp_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic accept, load_out, wr_ok;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    case (op_r)
      OP_INSERT:    wr_ok = (cnt_r < DEPTH_C) && (pos_r <= cnt_r);
      OP_REMOVE:    wr_ok = (pos_r < cnt_r);
      OP_OVERWRITE: wr_ok = (pos_r < cnt_r);
      default:      wr_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd.apply = (state_r == S_EXEC) && wr_ok;
    cmd.op    = op_r;
    cmd.pos   = pos_r;
    cmd.val   = val_r;
    cmd.cnt   = cnt_r;
    if (cnt_r == '0) cmd.target = '0;
    else if (pos_r >= cnt_r) cmd.target = POS_W'(cnt_r - CNT_W'(1));
    else cmd.target = pos_r;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    res_ok_nxt  = res_ok_r;
    res_rd_nxt  = res_rd_r;
    res_fp_nxt  = res_fp_r;
    res_cnt_nxt = res_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_nxt = (IDX_W+1)'(DEPTH);
          if (in_tuser inside {OP_READ, OP_SEARCH}) state_nxt = S_SCAN;
          else state_nxt = S_EXEC;
        end
      end
      S_SCAN: begin
        // token passes through each cell's register on its way to the chain end
        if (scan_r == '0) begin
          res_ok_nxt  = 1'b1;
          res_cnt_nxt = cnt_r;
          res_rd_nxt  = '0;
          res_fp_nxt  = '0;
          if (op_r == OP_READ) begin
            res_rd_nxt = (cnt_r == '0) ? EMPTY_READ : car_end.data;
          end else begin
            res_fp_nxt = car_end.found ? car_end.pos : POS_W'(cnt_r);
          end
          state_nxt = S_OUT;
        end else begin
          scan_nxt = scan_r - (IDX_W+1)'(1);
        end
      end
      S_EXEC: begin
        if (wr_ok && op_r == OP_INSERT) cnt_nxt = cnt_r + CNT_W'(1);
        else if (wr_ok && op_r == OP_REMOVE) cnt_nxt = cnt_r - CNT_W'(1);
        res_ok_nxt  = wr_ok;
        res_rd_nxt  = '0;
        res_fp_nxt  = '0;
        res_cnt_nxt = cnt_nxt;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      pos_r <= in_tdata[POS_W-1:0];
      val_r <= in_tdata[POS_W+DATA_W-1:POS_W];
    end
    res_ok_r  <= res_ok_nxt;
    res_rd_r  <= res_rd_nxt;
    res_fp_r  <= res_fp_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (load_out) begin
      out_data_r <= {7'd0,
                     (res_cnt_r == DEPTH_C),
                     (res_cnt_r == '0),
                     res_cnt_r,
                     res_fp_r,
                     res_rd_r,
                     res_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/indexed_sequence_store.sv
// Top level of the indexed sequence store: a chain of DEPTH entry cells
// driven by the request sequencer. Uses iss_pkg, iss_cell and iss_ctrl.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: op; tdata: position, value
//  out_    | out | out_tvalid/out_tready| tdata: ok, read, found, count, flags
//
// Read and search: the lookup token walks the cell chain one cell per cycle.
// Insert, remove, overwrite: all cells shift together in the same cycle.
// A new item is taken once the previous result sits in the output register,
// even while that result waits on out_tready.
// rst_n (synchronous) clears the count and control; entries are not cleared.
module indexed_sequence_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [6:0] position, [38:7] item_value, [39] zero
  input  logic [iss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] op
  input  logic [iss_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] ok, [32:1] read_value, [39:33] found_position, [46:40] item_count,
  // [47] is_empty, [48] is_full, [55:49] zero
  output logic [iss_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import iss_pkg::*;

  cmd_t              cmd;
  logic [DATA_W-1:0] cell_data [DEPTH];
  car_t              car_chain [DEPTH];
  car_t              car_head;

  assign car_head = '0;

  iss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .car_end    (car_chain[DEPTH-1])
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    car_t              car_in;

    if (g == 0) begin : g_first
      assign left_d = '0;
      assign car_in = car_head;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
      assign car_in = car_chain[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    iss_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[g]),
      .car_i      (car_in),
      .car_o      (car_chain[g])
    );
  end

endmodule

FILE: hw/rtl/iss_checker.sv
// Port-level checks for indexed_sequence_store, attached by bind.
// Uses iss_pkg for field widths and the store depth.
module iss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [iss_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [iss_pkg::OP_W-1:0]        in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [iss_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import iss_pkg::*;

  logic [CNT_W-1:0] o_cnt;
  logic             o_empty, o_full;

  assign o_cnt   = out_tdata[46:40];
  assign o_empty = out_tdata[47];
  assign o_full  = out_tdata[48];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item dropped or changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_empty == (o_cnt == '0)))
    else $error("is_empty disagrees with item_count");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_full == (o_cnt == CNT_W'(DEPTH))))
    else $error("is_full disagrees with item_count");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_cnt <= CNT_W'(DEPTH)))
    else $error("item_count beyond store depth");

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (.*);

FILE: tb/tb_indexed_sequence_store.sv
// Self-checking bench for indexed_sequence_store: directed table, then random traffic.
// Models the position-addressed store on its own and checks every result item.
// Depends on iss_pkg and the indexed_sequence_store top level.
module tb_indexed_sequence_store;
  import iss_pkg::*;

  localparam logic [OP_W-1:0]   OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0]   OP_RSVD_HI = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_NEG1   = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int SEGMENT_LEN  = 190;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int IDLE_LIMIT   = 3000;
  localparam int N_ROWS       = 25;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [CNT_W-1:0]  item_count;
    logic              is_empty;
    logic              is_full;
  } seq_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              typed;   // res holds a hand-written expectation
    seq_result_t       res;
  } stim_row_t;

  localparam seq_result_t EMPTY_RD = '{1'b1, EMPTY_READ, 7'd0, 7'd0, 1'b1, 1'b0};
  localparam seq_result_t EMPTY_OK = '{1'b1, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0};
  localparam seq_result_t EMPTY_NO = '{1'b0, 32'd0, 7'd0, 7'd0, 1'b1, 1'b0};
  localparam seq_result_t FOUR_NO  = '{1'b0, 32'd0, 7'd0, 7'd4, 1'b0, 1'b0};

  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    '{OP_READ,      7'd0,   32'd0,        1'b1, EMPTY_RD},
    '{OP_READ,      7'd127, VAL_NEG1,     1'b1, EMPTY_RD},
    '{OP_SEARCH,    7'd0,   32'd0,        1'b1, EMPTY_OK},
    '{OP_REMOVE,    7'd0,   32'd0,        1'b1, EMPTY_NO},
    '{OP_OVERWRITE, 7'd0,   VAL_MAX,      1'b1, EMPTY_NO},
    '{OP_INSERT,    7'd1,   32'd5,        1'b1, EMPTY_NO},
    '{OP_RSVD_HI,   7'd127, VAL_NEG1,     1'b1, EMPTY_NO},
    '{OP_INSERT,    7'd0,   VAL_MAX,      1'b1, '{1'b1, 32'd0, 7'd0, 7'd1, 1'b0, 1'b0}},
    '{OP_INSERT,    7'd1,   VAL_MIN,      1'b1, '{1'b1, 32'd0, 7'd0, 7'd2, 1'b0, 1'b0}},
    '{OP_INSERT,    7'd0,   EMPTY_READ,   1'b0, '0},
    '{OP_INSERT,    7'd3,   32'd0,        1'b0, '0},
    '{OP_INSERT,    7'd5,   32'd1,        1'b1, FOUR_NO},
    '{OP_READ,      7'd0,   32'd0,        1'b0, '0},
    '{OP_READ,      7'd4,   32'd0,        1'b0, '0},
    '{OP_READ,      7'd127, 32'd0,        1'b0, '0},
    '{OP_SEARCH,    7'd0,   VAL_MIN,      1'b0, '0},
    '{OP_SEARCH,    7'd0,   32'h1234_5678, 1'b0, '0},
    '{OP_OVERWRITE, 7'd4,   32'd9,        1'b1, FOUR_NO},
    '{OP_OVERWRITE, 7'd3,   VAL_MAX,      1'b0, '0},
    '{OP_SEARCH,    7'd0,   VAL_MAX,      1'b0, '0},
    '{OP_REMOVE,    7'd4,   32'd0,        1'b1, FOUR_NO},
    '{OP_REMOVE,    7'd0,   32'd0,        1'b0, '0},
    '{OP_REMOVE,    7'd2,   32'd0,        1'b0, '0},
    '{OP_RSVD_LO,   7'd127, VAL_MIN,      1'b0, '0},
    '{OP_READ,      7'd1,   32'd0,        1'b0, '0}
  };

  localparam logic [DATA_W-1:0] EXTREMES [4] = '{VAL_MIN, VAL_MAX, 32'd0, VAL_NEG1};

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [6:0] position, [38:7] item_value, [39] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [2:0] op
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [0] ok, [32:1] read_value, [39:33] found_position, [46:40] item_count,
  // [47] is_empty, [48] is_full, [55:49] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [DATA_W-1:0] shadow_seq [DEPTH];
  int                shadow_len;
  seq_result_t       pending_results [$];
  int                fail_count;
  int                idle_cycles;
  bit                no_idle;

  indexed_sequence_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow store and returns the result it gives.
  task automatic predict_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val, output seq_result_t r);
    int i;
    r = '0;
    case (op)
      OP_READ: begin
        r.ok = 1'b1;
        if (shadow_len == 0) r.read_value = EMPTY_READ;
        else if (pos >= shadow_len) r.read_value = shadow_seq[shadow_len-1];
        else r.read_value = shadow_seq[pos];
      end
      OP_SEARCH: begin
        r.ok = 1'b1;
        r.found_position = POS_W'(shadow_len);
        // walk down so the lowest match wins
        for (i = shadow_len - 1; i >= 0; i--)
          if (shadow_seq[i] == val) r.found_position = POS_W'(i);
      end
      OP_INSERT: begin
        if (shadow_len < DEPTH && pos <= shadow_len) begin
          for (i = shadow_len; i > pos; i--) shadow_seq[i] = shadow_seq[i-1];
          shadow_seq[pos] = val;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_len) begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_seq[i] = shadow_seq[i+1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      OP_OVERWRITE: begin
        if (pos < shadow_len) begin
          shadow_seq[pos] = val;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.item_count = CNT_W'(shadow_len);
    r.is_empty   = (shadow_len == 0);
    r.is_full    = (shadow_len >= DEPTH);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Drives one item; the expectation is queued at the accepting edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val, input logic typed,
                           input seq_result_t typed_res);
    int          gap;
    seq_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    predict_request(op, pos, val, pred);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Result side: random back-pressure
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    seq_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding: 0x%0h", out_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("ok", exp_r.ok, out_tdata[0]);
        compare_field("read_value", exp_r.read_value, out_tdata[32:1]);
        compare_field("found_position", exp_r.found_position, out_tdata[39:33]);
        compare_field("item_count", exp_r.item_count, out_tdata[46:40]);
        compare_field("is_empty", exp_r.is_empty, out_tdata[47]);
        compare_field("is_full", exp_r.is_full, out_tdata[48]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int               seg, k, r, ins_w, rem_w;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
    bit               grow;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    fail_count  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    shadow_len  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_ROWS; k++)
      send_item(DIR_ROWS[k].op, DIR_ROWS[k].pos, DIR_ROWS[k].val,
                DIR_ROWS[k].typed, DIR_ROWS[k].res);

    // Segments alternate between filling and draining so both full and
    // empty are reached repeatedly; every fourth segment runs without gaps.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      seg     = k / SEGMENT_LEN;
      grow    = (seg % 2 == 0);
      no_idle = (seg % 4 == 3);
      ins_w   = grow ? 55 : 10;
      rem_w   = grow ? 10 : 55;

      r = $urandom_range(0, 99);
      if (r < ins_w) op = OP_INSERT;
      else if (r < ins_w + rem_w) op = OP_REMOVE;
      else if (r < 77) op = OP_READ;
      else if (r < 89) op = OP_SEARCH;
      else if (r < 97) op = OP_OVERWRITE;
      else op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));

      r = $urandom_range(0, 99);
      if (op == OP_INSERT)
        pos = (r < 85) ? POS_W'($urandom_range(0, shadow_len))
                       : POS_W'($urandom_range(0, 127));
      else if (r < 85 && shadow_len > 0) pos = POS_W'($urandom_range(0, shadow_len - 1));
      else if (r < 92) pos = POS_W'(shadow_len);
      else pos = POS_W'($urandom_range(0, 127));

      // small values give duplicates, so first-match order gets exercised
      r = $urandom_range(0, 99);
      if (op == OP_SEARCH && shadow_len > 0 && r < 50)
        val = shadow_seq[$urandom_range(0, shadow_len - 1)];
      else if (r < 60) val = $urandom;
      else if (r < 85) val = $urandom_range(0, 7);
      else val = EXTREMES[$urandom_range(0, 3)];

      send_item(op, pos, val, 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
